FILE: rtl/core/multi_slot_repeat_timer_table_top_assert.svh
// Assertion macros used by the timer table datapath.
// Each macro takes a label, the clock, the active-low reset and the terms.
`ifndef MULTI_SLOT_REPEAT_TIMER_TABLE_TOP_ASSERT_SVH
`define MULTI_SLOT_REPEAT_TIMER_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define MSRTT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table assertion failed");
// The consequent holds in the cycle after the antecedent.
`define MSRTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table assertion failed");
`else
`define MSRTT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MSRTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/msrtt_pkg.sv
package msrtt_pkg;

    // Field widths of the item and result beats.
    localparam int MODE_W = 3;
    localparam int ID_W   = 4;
    localparam int IVAL_W = 24;
    localparam int CNT_W  = 32;
    localparam int ELAP_W = 16;
    localparam int STAT_W = 2;

    // Minimum interval after reset, in milliseconds.
    localparam logic [IVAL_W-1:0] MIN_INTERVAL_RST = 24'd50;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_KILL     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_IVAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_CNT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd6;

    // Result kinds.
    localparam logic KIND_FIRE  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Reply status codes.
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_INACTIVE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic tick_step;
        logic flush;
        logic create_take;
        logic create_next;
        logic create_full;
        logic exec;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              fire;
        logic              slot_free;
        logic              idx_last;
        logic              out_free;
        logic              pend_valid;
    } dp_stat_t;

endpackage

FILE: rtl/core/msrtt_ram.sv
module msrtt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/msrtt_ctrl.sv
module msrtt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msrtt_pkg::dp_stat_t   stat,
    output msrtt_pkg::ctrl_cmd_t  cmd
);
    import msrtt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_TICK   = 6'b000100,
        ST_FLUSH  = 6'b001000,
        ST_CREATE = 6'b010000,
        ST_CMD    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one item at a time.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // The slot read issued here is available in the next state.
                case (stat.mode)
                    MODE_TICK:   state_next = ST_TICK;
                    MODE_CREATE: state_next = ST_CREATE;
                    MODE_KILL, MODE_SET_IVAL, MODE_SET_CNT, MODE_QUERY, MODE_CLEAR:
                        state_next = ST_CMD;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_TICK:
            begin
                // A second due slot must wait until the held event can leave.
                if (!(stat.fire && stat.pend_valid && !stat.out_free))
                begin
                    cmd.tick_step = 1'b1;
                    if (stat.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CREATE:
            begin
                if (stat.slot_free)
                begin
                    if (stat.out_free)
                    begin
                        cmd.create_take = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (stat.idx_last)
                begin
                    if (stat.out_free)
                    begin
                        cmd.create_full = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.create_next = 1'b1;
                end
            end
            ST_CMD:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/msrtt_dp.sv
`include "multi_slot_repeat_timer_table_top_assert.svh"

module msrtt_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  msrtt_pkg::ctrl_cmd_t             cmd,
    output msrtt_pkg::dp_stat_t              stat,
    input  logic                             cfg_valid,
    input  logic [msrtt_pkg::IVAL_W-1:0]     cfg_data,
    input  logic [msrtt_pkg::MODE_W-1:0]     mode,
    input  logic [msrtt_pkg::ID_W-1:0]       timer_id,
    input  logic [msrtt_pkg::IVAL_W-1:0]     interval_ms,
    input  logic [msrtt_pkg::CNT_W-1:0]      execute_count,
    input  logic [msrtt_pkg::ELAP_W-1:0]     elapsed_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [msrtt_pkg::ID_W-1:0]       slot_id,
    output logic [msrtt_pkg::STAT_W-1:0]     status,
    output logic [msrtt_pkg::IVAL_W-1:0]     interval_out,
    output logic [msrtt_pkg::CNT_W-1:0]      count_out,
    output logic                             last
);
    import msrtt_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Item held while it is worked on.
    logic [MODE_W-1:0] mode_reg;
    logic [ID_W-1:0]   id_reg;
    logic [IVAL_W-1:0] ival_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ELAP_W-1:0] elap_reg;

    logic [IVAL_W-1:0]    min_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] valid_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [IDX_W-1:0]     pend_slot_reg;
    logic [IDX_W-1:0]     pend_slot_next;

    // Output register.
    logic              out_valid_reg;
    logic              kind_reg;
    logic [ID_W-1:0]   slot_reg;
    logic [STAT_W-1:0] status_reg;
    logic [IVAL_W-1:0] ival_out_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic              last_reg;

    logic              push;
    logic              kind_next;
    logic [ID_W-1:0]   slot_next;
    logic [STAT_W-1:0] status_next;
    logic [IVAL_W-1:0] ival_out_next;
    logic [CNT_W-1:0]  cnt_out_next;
    logic              last_next;

    // Slot store read and write side.
    logic [IDX_W-1:0]  rd_base;
    logic [IDX_W-1:0]  rd_addr;
    logic [IVAL_W-1:0] rd_ival;
    logic [IVAL_W-1:0] rd_cd;
    logic [CNT_W:0]    rd_rem;
    logic              ival_we;
    logic              cd_we;
    logic [IVAL_W-1:0] cd_wdata;
    logic              rem_we;
    logic [CNT_W:0]    rem_wdata;

    logic              out_free;
    logic              id_in_range;
    logic              idx_in_range;
    logic              active;
    logic              slot_vld;
    logic              idx_last;
    logic              due;
    logic              fire;
    logic              endless;
    logic              frees;
    logic [IVAL_W-1:0] elap_ext;
    logic [IVAL_W-1:0] min_eff;
    logic [IVAL_W-1:0] clamped;

    // Slot decode and per-slot tick decisions.
    assign id_in_range  = int'(id_reg) < NUM_SLOTS;
    assign idx_in_range = int'(idx_reg) < NUM_SLOTS;
    assign slot_vld     = idx_in_range && valid_reg[idx_reg];
    assign active       = id_in_range && slot_vld;
    assign idx_last     = idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign elap_ext     = IVAL_W'(elap_reg);
    assign due          = rd_cd <= elap_ext;
    assign fire         = slot_vld && due;
    assign endless      = rd_rem[CNT_W];
    assign frees        = fire && !endless && (rd_rem[CNT_W-1:0] <= CNT_W'(1));
    assign out_free     = !out_valid_reg || out_ready;

    // Interval clamp; a minimum of zero acts as one.
    assign min_eff = (min_reg == '0) ? IVAL_W'(1) : min_reg;
    assign clamped = (ival_reg < min_eff) ? min_eff : ival_reg;

    // Read address moves ahead one slot as the tick scan advances.
    assign rd_base = idx_in_range ? idx_reg : '0;
    assign rd_addr = (cmd.tick_step && !idx_last) ? idx_reg + IDX_W'(1) : rd_base;

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.fire       = fire;
        stat.slot_free  = !slot_vld;
        stat.idx_last   = idx_last;
        stat.out_free   = out_free;
        stat.pend_valid = pend_valid_reg;
    end

    // Store write enables and data.
    always_comb
    begin
        ival_we   = cmd.create_take || (cmd.exec && mode_reg == MODE_SET_IVAL && active);
        cd_we     = ival_we || (cmd.tick_step && slot_vld);
        cd_wdata  = clamped;
        rem_we    = cmd.create_take || (cmd.exec && mode_reg == MODE_SET_CNT && active);
        rem_wdata = {cnt_reg == '0, cnt_reg};
        if (cmd.tick_step)
        begin
            cd_wdata  = due ? rd_ival : rd_cd - elap_ext;
            rem_we    = fire && !endless;
            rem_wdata = {1'b0, rd_rem[CNT_W-1:0] - CNT_W'(1)};
        end
    end

    msrtt_ram #(.WIDTH(IVAL_W), .DEPTH(NUM_SLOTS), .ADDR_W(IDX_W)) u_ival_ram (
        .clk   (clk),
        .we    (ival_we),
        .waddr (idx_reg),
        .wdata (clamped),
        .raddr (rd_addr),
        .rdata (rd_ival)
    );

    msrtt_ram #(.WIDTH(IVAL_W), .DEPTH(NUM_SLOTS), .ADDR_W(IDX_W)) u_cd_ram (
        .clk   (clk),
        .we    (cd_we),
        .waddr (idx_reg),
        .wdata (cd_wdata),
        .raddr (rd_addr),
        .rdata (rd_cd)
    );

    msrtt_ram #(.WIDTH(CNT_W + 1), .DEPTH(NUM_SLOTS), .ADDR_W(IDX_W)) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (idx_reg),
        .wdata (rem_wdata),
        .raddr (rd_addr),
        .rdata (rd_rem)
    );

    // Slot index, valid marks and the held fire event.
    always_comb
    begin
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        if (cmd.accept)
        begin
            idx_next        = (mode == MODE_TICK || mode == MODE_CREATE) ? '0
                                                                       : IDX_W'(timer_id);
            pend_valid_next = 1'b0;
        end
        if (cmd.tick_step || cmd.create_next)
        begin
            idx_next = idx_last ? idx_reg : idx_reg + IDX_W'(1);
        end
        if (cmd.tick_step && fire)
        begin
            pend_valid_next = 1'b1;
            pend_slot_next  = idx_reg;
        end
        if (cmd.tick_step && frees)
        begin
            valid_next[idx_reg] = 1'b0;
        end
        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
        if (cmd.create_take)
        begin
            valid_next[idx_reg] = 1'b1;
        end
        if (cmd.exec && mode_reg == MODE_KILL && active)
        begin
            valid_next[idx_reg] = 1'b0;
        end
        if (cmd.exec && mode_reg == MODE_CLEAR)
        begin
            valid_next = '0;
        end
    end

    // Result beat selection.
    always_comb
    begin
        push          = 1'b0;
        kind_next     = KIND_REPLY;
        slot_next     = ID_W'(idx_reg);
        status_next   = STATUS_OK;
        ival_out_next = '0;
        cnt_out_next  = '0;
        last_next     = 1'b1;
        if (cmd.tick_step && fire && pend_valid_reg)
        begin
            push      = 1'b1;
            kind_next = KIND_FIRE;
            slot_next = ID_W'(pend_slot_reg);
            last_next = 1'b0;
        end
        if (cmd.flush)
        begin
            push      = 1'b1;
            kind_next = KIND_FIRE;
            slot_next = ID_W'(pend_slot_reg);
        end
        if (cmd.create_take)
        begin
            push = 1'b1;
        end
        if (cmd.create_full)
        begin
            push        = 1'b1;
            slot_next   = '0;
            status_next = STATUS_FULL;
        end
        if (cmd.exec)
        begin
            push        = 1'b1;
            slot_next   = id_reg;
            status_next = active ? STATUS_OK : STATUS_INACTIVE;
            if (mode_reg == MODE_CLEAR)
            begin
                slot_next   = '0;
                status_next = STATUS_OK;
            end
            if (mode_reg == MODE_QUERY && active)
            begin
                ival_out_next = rd_ival;
                cnt_out_next  = endless ? '0 : rd_rem[CNT_W-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= MIN_INTERVAL_RST;
            idx_reg        <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        if (cmd.accept)
        begin
            mode_reg <= mode;
            id_reg   <= timer_id;
            ival_reg <= interval_ms;
            cnt_reg  <= execute_count;
            elap_reg <= elapsed_ms;
        end
        if (push)
        begin
            kind_reg     <= kind_next;
            slot_reg     <= slot_next;
            status_reg   <= status_next;
            ival_out_reg <= ival_out_next;
            cnt_out_reg  <= cnt_out_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign slot_id      = slot_reg;
    assign status       = status_reg;
    assign interval_out = ival_out_reg;
    assign count_out    = cnt_out_reg;
    assign last         = last_reg;

    // A beat is only loaded when the output register can take it.
    `MSRTT_ASSERT_IMPLIES(a_push_free, clk, rst_n, push, out_free)
    // The store is never read outside the slot range.
    `MSRTT_ASSERT_IMPLIES(a_rd_in_range, clk, rst_n, 1'b1, int'(rd_addr) < NUM_SLOTS)
    // No fire event is left over from the previous tick.
    `MSRTT_ASSERT_IMPLIES(a_pend_clear, clk, rst_n, cmd.accept, !pend_valid_reg)
    // A created slot is marked in use in the following cycle.
    `MSRTT_ASSERT_NEXT(a_create_mark, clk, rst_n, cmd.create_take, valid_reg[$past(idx_reg)])

endmodule

FILE: rtl/core/multi_slot_repeat_timer_table_top.sv
// Timer table with a fixed number of slots; timer ids are slot numbers.
// Input channel (in_valid/in_ready): one beat per command or tick item.
// Output channel (out_valid/out_ready): result beats; last marks the final
// beat of an item. A tick gives one fire beat per due slot in ascending
// slot order, possibly none; other defined modes give exactly one reply.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the minimum
// interval; it is always ready and is meant to be used while idle.
// Items are worked on one at a time. A tick passes through accept, a slot
// store read, a scan of one slot per cycle through the slot memories
// (one write and one registered read port each) unless a stall holds it,
// and a final step to release the held fire event. Create scans the
// in-use marks one slot per cycle; other commands read a slot and execute.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls, the scan holds on a due slot until the previous
// fire event has been taken; no beat is dropped.
// Reset empties the table and sets the minimum interval to 50 ms. There is
// no clearing pass; slot contents are written when a timer is created.
module multi_slot_repeat_timer_table_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msrtt_pkg::IVAL_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msrtt_pkg::MODE_W-1:0] mode,
    input  logic [msrtt_pkg::ID_W-1:0]   timer_id,
    input  logic [msrtt_pkg::IVAL_W-1:0] interval_ms,
    input  logic [msrtt_pkg::CNT_W-1:0]  execute_count,
    input  logic [msrtt_pkg::ELAP_W-1:0] elapsed_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [msrtt_pkg::ID_W-1:0]   slot_id,
    output logic [msrtt_pkg::STAT_W-1:0] status,
    output logic [msrtt_pkg::IVAL_W-1:0] interval_out,
    output logic [msrtt_pkg::CNT_W-1:0]  count_out,
    output logic                         last
);
    import msrtt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // The minimum interval register takes every configuration beat.
    assign cfg_ready = 1'b1;

    msrtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msrtt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .timer_id      (timer_id),
        .interval_ms   (interval_ms),
        .execute_count (execute_count),
        .elapsed_ms    (elapsed_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .slot_id       (slot_id),
        .status        (status),
        .interval_out  (interval_out),
        .count_out     (count_out),
        .last          (last)
    );

endmodule
